// ===== rtl/mbrtu_pkg.sv =====
package mbrtu_pkg;

	localparam int MAX_REPLY_BYTES_DEF = 8;
	localparam int FRAME_BYTES = 6;
	localparam int WRITE_REPLY_LIMIT = 8;
	localparam int READ_REPLY_LIMIT = 7;
	localparam int MIN_REPLY_BYTES = 5;

	localparam logic [7:0] FUNC_WRITE_REG = 8'h06;
	localparam logic [7:0] FUNC_WRITE_COIL = 8'h05;
	localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
	localparam logic [7:0] EXC_FLAG = 8'h80;
	localparam logic [7:0] CRC_HIGH_MASK = 8'hF8;
	localparam logic [7:0] BYTE_COUNT_ONE_REG = 8'h02;
	localparam logic [7:0] COIL_ON_HIGH = 8'hFF;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [2:0] TX_IDX_CRC_LO = 3'd6;
	localparam logic [2:0] TX_IDX_CRC_HI = 3'd7;

	typedef enum logic [1:0] {
		CMD_START,
		CMD_RX_BYTE,
		CMD_END
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_WRITE_REG,
		KIND_WRITE_COIL,
		KIND_READ_INPUT
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT,
		ST_BAD_DEVICE,
		ST_BAD_CRC,
		ST_BAD_REPLY,
		ST_EXCEPTION
	} status_t;

	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic crc_match(input logic [15:0] crc, input logic [7:0] lo,
			input logic [7:0] hi);
		return (lo == crc[7:0]) && ((hi & CRC_HIGH_MASK) == (crc[15:8] & CRC_HIGH_MASK));
	endfunction

endpackage

// ===== rtl/mbrtu_in_if.sv =====
interface mbrtu_in_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [1:0] request_kind;
	logic [7:0] device;
	logic [15:0] reg_address;
	logic [15:0] write_value;
	logic [7:0] rx_byte;

	modport source (
		output valid, command, request_kind, device, reg_address, write_value, rx_byte,
		input ready
	);
	modport sink (
		input valid, command, request_kind, device, reg_address, write_value, rx_byte,
		output ready
	);
endinterface

// ===== rtl/mbrtu_out_if.sv =====
interface mbrtu_out_if;
	logic valid;
	logic ready;
	logic result_kind;
	logic [7:0] tx_byte;
	logic tx_last;
	logic [2:0] status;
	logic [7:0] exception_code;
	logic [15:0] read_value;

	modport source (
		output valid, result_kind, tx_byte, tx_last, status, exception_code, read_value,
		input ready
	);
	modport sink (
		input valid, result_kind, tx_byte, tx_last, status, exception_code, read_value,
		output ready
	);
endinterface

// ===== rtl/modbus_rtu_master_transaction_checker_unit.sv =====
// Reply byte and end-of-reply transfers are taken one per cycle while the output is free and no
// frame is being sent; a status appears in the cycle after its end-of-reply transfer.
// A start transfer sends eight frame bytes, one per cycle while the output is free, and the
// input is held off while they go out.
// The frame CRC is built in the byte sequencer, one byte of the CRC update per cycle while the output is free.
// Asynchronous reset clears the request frame, the reply count and the CRCs (to FFFF).
module modbus_rtu_master_transaction_checker_unit #(
	parameter int MAX_REPLY_BYTES = mbrtu_pkg::MAX_REPLY_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	mbrtu_in_if.sink din,
	mbrtu_out_if.source dout
);
	import mbrtu_pkg::*;

	localparam int CNT_W = $clog2(MAX_REPLY_BYTES + 1);
	localparam int IDX_W = $clog2(MAX_REPLY_BYTES);
	localparam int WR_LIM_I = (WRITE_REPLY_LIMIT < MAX_REPLY_BYTES) ? WRITE_REPLY_LIMIT
		: MAX_REPLY_BYTES;
	localparam int RD_LIM_I = (READ_REPLY_LIMIT < MAX_REPLY_BYTES) ? READ_REPLY_LIMIT
		: MAX_REPLY_BYTES;
	localparam logic [CNT_W-1:0] WR_LIM = CNT_W'(WR_LIM_I);
	localparam logic [CNT_W-1:0] RD_LIM = CNT_W'(RD_LIM_I);
	localparam logic [CNT_W-1:0] WR_FULL = CNT_W'(WRITE_REPLY_LIMIT);
	localparam logic [CNT_W-1:0] RD_FULL = CNT_W'(READ_REPLY_LIMIT);
	localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_REPLY_BYTES);
	localparam logic [CNT_W-1:0] THREE_CNT = CNT_W'(3);

	logic [7:0] frame_q [FRAME_BYTES];
	kind_t pending_q;
	logic [7:0] store_q [MAX_REPLY_BYTES];
	logic [CNT_W-1:0] cnt_q;
	logic [15:0] crc_run_q;
	logic [15:0] crc_one_q;
	logic [15:0] crc_two_q;
	logic [15:0] crc_three_q;
	logic [7:0] last_q;
	logic [7:0] prev_q;

	logic tx_busy_q;
	logic [2:0] tx_idx_q;
	logic [15:0] tx_crc_q;

	logic out_valid_q;
	logic out_kind_q;
	logic [7:0] out_tx_q;
	logic out_last_q;
	status_t out_status_q;
	logic [7:0] out_exc_q;
	logic [15:0] out_val_q;

	logic out_free;
	logic accept;
	logic kind_ok;
	logic is_start;
	logic is_rx;
	logic is_end;
	logic rx_take;
	logic [CNT_W-1:0] rx_limit;
	logic [15:0] rx_crc;
	logic [7:0] new_frame [FRAME_BYTES];
	logic [7:0] tx_byte_d;
	logic [7:0] func_exc;
	logic crc3_ok;
	logic crcn_ok;
	logic echo_ok;
	status_t st_d;
	logic [7:0] exc_d;
	logic [15:0] val_d;

	assign out_free = !out_valid_q || dout.ready;
	assign din.ready = !tx_busy_q && out_free;
	assign accept = din.valid && din.ready;

	assign kind_ok = (din.request_kind == KIND_WRITE_REG) || (din.request_kind == KIND_WRITE_COIL)
		|| (din.request_kind == KIND_READ_INPUT);
	assign is_start = accept && (din.command == CMD_START) && kind_ok;
	assign is_rx = accept && (din.command == CMD_RX_BYTE);
	assign is_end = accept && (din.command == CMD_END);

	assign rx_limit = (pending_q == KIND_READ_INPUT) ? RD_LIM : WR_LIM;
	assign rx_take = is_rx && (cnt_q < rx_limit);
	assign rx_crc = crc16_update(crc_run_q, din.rx_byte);

	always_comb begin
		new_frame[0] = din.device;
		new_frame[2] = din.reg_address[15:8];
		new_frame[3] = din.reg_address[7:0];
		unique case (din.request_kind)
			KIND_WRITE_REG: begin
				new_frame[1] = FUNC_WRITE_REG;
				new_frame[4] = din.write_value[15:8];
				new_frame[5] = din.write_value[7:0];
			end
			KIND_WRITE_COIL: begin
				new_frame[1] = FUNC_WRITE_COIL;
				new_frame[4] = (din.write_value != 16'h0000) ? COIL_ON_HIGH : 8'h00;
				new_frame[5] = 8'h00;
			end
			default: begin
				new_frame[1] = FUNC_READ_INPUT;
				new_frame[4] = 8'h00;
				new_frame[5] = 8'h01;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				frame_q[i] <= 8'h00;
			end
			pending_q <= KIND_WRITE_REG;
			cnt_q <= '0;
			crc_run_q <= CRC_INIT;
			crc_one_q <= CRC_INIT;
			crc_two_q <= CRC_INIT;
			crc_three_q <= CRC_INIT;
		end else if (is_start || is_end) begin
			if (is_start) begin
				frame_q <= new_frame;
				pending_q <= kind_t'(din.request_kind);
			end
			cnt_q <= '0;
			crc_run_q <= CRC_INIT;
			crc_one_q <= CRC_INIT;
			crc_two_q <= CRC_INIT;
			crc_three_q <= CRC_INIT;
		end else if (rx_take) begin
			cnt_q <= cnt_q + 1'b1;
			crc_two_q <= crc_one_q;
			crc_one_q <= crc_run_q;
			crc_run_q <= rx_crc;
			if (cnt_q + 1'b1 == THREE_CNT) begin
				crc_three_q <= rx_crc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			store_q[cnt_q[IDX_W-1:0]] <= din.rx_byte;
			last_q <= din.rx_byte;
			prev_q <= last_q;
		end
	end

	assign func_exc = frame_q[1] | EXC_FLAG;
	assign crc3_ok = crc_match(crc_three_q, store_q[3], store_q[4]);
	assign crcn_ok = crc_match(crc_two_q, prev_q, last_q);

	always_comb begin
		echo_ok = 1'b1;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			if (store_q[i] != frame_q[i]) begin
				echo_ok = 1'b0;
			end
		end
	end

	always_comb begin
		st_d = ST_OK;
		exc_d = 8'h00;
		val_d = 16'h0000;
		priority if (cnt_q < MIN_CNT) begin
			st_d = ST_SHORT;
		end else if (pending_q == KIND_WRITE_REG) begin
			priority if (store_q[0] != frame_q[0]) begin
				st_d = ST_BAD_DEVICE;
			end else if (store_q[1] == func_exc) begin
				if (crc3_ok) begin
					st_d = ST_EXCEPTION;
					exc_d = store_q[2];
				end else begin
					st_d = ST_BAD_CRC;
				end
			end else if (cnt_q < WR_FULL) begin
				st_d = ST_SHORT;
			end else if (!crcn_ok) begin
				st_d = ST_BAD_CRC;
			end else if (!echo_ok) begin
				st_d = ST_BAD_REPLY;
			end else begin
				st_d = ST_OK;
			end
		end else if (!crcn_ok) begin
			st_d = ST_BAD_CRC;
		end else if (store_q[0] != frame_q[0]) begin
			st_d = ST_BAD_DEVICE;
		end else if (store_q[1] == func_exc) begin
			st_d = ST_EXCEPTION;
			exc_d = store_q[2];
		end else if (pending_q == KIND_WRITE_COIL) begin
			priority if (cnt_q < WR_FULL) begin
				st_d = ST_SHORT;
			end else if (!echo_ok) begin
				st_d = ST_BAD_REPLY;
			end else begin
				st_d = ST_OK;
			end
		end else if (cnt_q < RD_FULL) begin
			st_d = ST_SHORT;
		end else if (store_q[2] != BYTE_COUNT_ONE_REG) begin
			st_d = ST_BAD_REPLY;
		end else begin
			st_d = ST_OK;
			val_d = {store_q[3], store_q[4]};
		end
	end

	always_comb begin
		priority if (tx_idx_q == TX_IDX_CRC_LO) begin
			tx_byte_d = tx_crc_q[7:0];
		end else if (tx_idx_q == TX_IDX_CRC_HI) begin
			tx_byte_d = tx_crc_q[15:8];
		end else begin
			tx_byte_d = frame_q[tx_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_busy_q <= 1'b0;
			tx_idx_q <= '0;
			tx_crc_q <= CRC_INIT;
		end else if (is_start) begin
			tx_busy_q <= 1'b1;
			tx_idx_q <= '0;
			tx_crc_q <= CRC_INIT;
		end else if (tx_busy_q && out_free) begin
			tx_idx_q <= tx_idx_q + 1'b1;
			if (tx_idx_q < TX_IDX_CRC_LO) begin
				tx_crc_q <= crc16_update(tx_crc_q, tx_byte_d);
			end
			if (tx_idx_q == TX_IDX_CRC_HI) begin
				tx_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= tx_busy_q || is_end;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (tx_busy_q) begin
				out_kind_q <= 1'b0;
				out_tx_q <= tx_byte_d;
				out_last_q <= (tx_idx_q == TX_IDX_CRC_HI);
				out_status_q <= ST_OK;
				out_exc_q <= 8'h00;
				out_val_q <= 16'h0000;
			end else if (is_end) begin
				out_kind_q <= 1'b1;
				out_tx_q <= 8'h00;
				out_last_q <= 1'b0;
				out_status_q <= st_d;
				out_exc_q <= exc_d;
				out_val_q <= val_d;
			end
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.result_kind = out_kind_q;
	assign dout.tx_byte = out_tx_q;
	assign dout.tx_last = out_last_q;
	assign dout.status = out_status_q;
	assign dout.exception_code = out_exc_q;
	assign dout.read_value = out_val_q;

`ifndef SYNTHESIS
	a_start_opens_frame: assert property (@(posedge clk) disable iff (!arst_n)
		is_start |=> tx_busy_q && (tx_idx_q == 3'd0))
		else $error("A start transfer did not open the frame sequencer.");

	a_frame_closes: assert property (@(posedge clk) disable iff (!arst_n)
		tx_busy_q && out_free && (tx_idx_q == TX_IDX_CRC_HI) |=> !tx_busy_q && dout.valid
		&& dout.tx_last)
		else $error("The frame did not close with its last byte.");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= WR_LIM)
		else $error("The reply count ran past its limit.");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.result_kind |-> (dout.tx_byte == 8'h00) && !dout.tx_last)
		else $error("A status result carries frame byte fields.");

	a_last_is_frame: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.tx_last |-> !dout.result_kind && (dout.status == ST_OK))
		else $error("A last-byte marker appeared outside a frame byte.");
`endif

endmodule
